// ===== sv/tlrag_pkg.sv =====
// Shared types, constants and helper functions for the layout rotate address generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tlrag_pkg;

    localparam int DIM_BITS   = 8;
    localparam int DIM_W      = DIM_BITS + 1;
    localparam int CFG_DIM_W  = 9;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int IDX_W      = 32;

    localparam int P1_W = 2 * DIM_BITS + 1;
    localparam int P2_W = 3 * DIM_BITS + 1;
    localparam int P3_W = 4 * DIM_BITS + 1;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int BACK_STAGES = 3;
    localparam int OUT_CAP     = FIFO_DEPTH + BACK_STAGES;
    localparam int CHK_CNT_W   = $clog2(OUT_CAP + 1) + 1;

    localparam logic [31:0] DIM_MAX = 32'(1) << DIM_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_BATCH      = 3'd0,
        REG_DIM_HEIGHT     = 3'd1,
        REG_DIM_WIDTH      = 3'd2,
        REG_DIM_CHANNELS   = 3'd3,
        REG_TRANSFORM_MODE = 3'd4
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ROT_LEFT       = 3'd0,
        MODE_ROT_RIGHT      = 3'd1,
        MODE_REFL_X         = 3'd2,
        MODE_REFL_Y         = 3'd3,
        MODE_REFL_BOTH      = 3'd4,
        MODE_TRANSPOSE      = 3'd5,
        MODE_REFL_X_ROT_RIGHT = 3'd6
    } mode_t;

    typedef struct packed {
        logic rot;
        logic flip_h;
        logic flip_w;
    } xform_t;

    typedef struct packed {
        logic [DIM_W-1:0] hd;
        logic [DIM_W-1:0] wd;
        logic [DIM_W-1:0] cd;
    } dims_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] n;
        logic [DIM_BITS-1:0] c;
        logic [DIM_BITS-1:0] h;
        logic [DIM_BITS-1:0] w;
        logic [IDX_W-1:0]    dest;
        logic                last;
    } coord_t;

    // zero counts as one, oversize saturates
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] v);
        logic [31:0] vx;
        vx = 32'(v);
        if (vx == 32'd0) begin
            return DIM_W'(1);
        end
        if (vx > DIM_MAX) begin
            return DIM_W'(DIM_MAX);
        end
        return DIM_W'(vx);
    endfunction

    // unused code seven falls back to rotate left
    function automatic xform_t decode_mode(input logic [MODE_W-1:0] m);
        xform_t x;
        case (m) inside
            MODE_ROT_LEFT:         x = '{rot: 1'b1, flip_h: 1'b0, flip_w: 1'b1};
            MODE_ROT_RIGHT:        x = '{rot: 1'b1, flip_h: 1'b1, flip_w: 1'b0};
            MODE_REFL_X:           x = '{rot: 1'b0, flip_h: 1'b0, flip_w: 1'b1};
            MODE_REFL_Y:           x = '{rot: 1'b0, flip_h: 1'b1, flip_w: 1'b0};
            MODE_REFL_BOTH:        x = '{rot: 1'b0, flip_h: 1'b1, flip_w: 1'b1};
            MODE_TRANSPOSE:        x = '{rot: 1'b1, flip_h: 1'b0, flip_w: 1'b0};
            MODE_REFL_X_ROT_RIGHT: x = '{rot: 1'b1, flip_h: 1'b1, flip_w: 1'b1};
            default:               x = '{rot: 1'b1, flip_h: 1'b0, flip_w: 1'b1};
        endcase
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tlrag_front.sv =====
// Front end: configuration registers, nested walk counters and coordinate transform.
// Produces one coordinate request per accepted step. Depends on tlrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrag_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlrag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlrag_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output tlrag_pkg::coord_t                q_data,
    output tlrag_pkg::dims_t                 dims
);
    import tlrag_pkg::*;

    logic [CFG_DIM_W-1:0] dim_batch_reg;
    logic [CFG_DIM_W-1:0] dim_height_reg;
    logic [CFG_DIM_W-1:0] dim_width_reg;
    logic [CFG_DIM_W-1:0] dim_channels_reg;
    logic [MODE_W-1:0]    mode_reg;

    logic [DIM_BITS-1:0] batch_reg, channel_reg, outer_reg, inner_reg;
    logic [IDX_W-1:0]    position_reg;
    logic [DIM_BITS-1:0] batch_next, channel_next, outer_next, inner_next;
    logic [IDX_W-1:0]    position_next;

    logic [DIM_BITS-1:0] b_n, b_c, b_o, b_i;
    logic [IDX_W-1:0]    b_pos;
    logic [DIM_W-1:0]    nd, hd, wd, cd, outer_lim, inner_lim;
    logic [DIM_W-1:0]    inner_inc, outer_inc, channel_inc, batch_inc;
    logic [DIM_BITS-1:0] hc, wc;
    xform_t              xf;
    logic                cfg_hit, accept, last;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;

    always_comb begin
        case (cfg_index) inside
            REG_DIM_BATCH, REG_DIM_HEIGHT, REG_DIM_WIDTH, REG_DIM_CHANNELS,
            REG_TRANSFORM_MODE: cfg_hit = cfg_valid;
            default:            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_batch_reg    <= CFG_DIM_W'(1);
            dim_height_reg   <= CFG_DIM_W'(1);
            dim_width_reg    <= CFG_DIM_W'(1);
            dim_channels_reg <= CFG_DIM_W'(1);
            mode_reg         <= MODE_ROT_LEFT;
        end else if (cfg_hit) begin
            case (cfg_index)
                REG_DIM_BATCH:      dim_batch_reg    <= cfg_data[CFG_DIM_W-1:0];
                REG_DIM_HEIGHT:     dim_height_reg   <= cfg_data[CFG_DIM_W-1:0];
                REG_DIM_WIDTH:      dim_width_reg    <= cfg_data[CFG_DIM_W-1:0];
                REG_DIM_CHANNELS:   dim_channels_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_TRANSFORM_MODE: mode_reg         <= cfg_data[MODE_W-1:0];
                default:            mode_reg         <= mode_reg;
            endcase
        end
    end

    always_comb begin
        nd = eff_dim(dim_batch_reg);
        hd = eff_dim(dim_height_reg);
        wd = eff_dim(dim_width_reg);
        cd = eff_dim(dim_channels_reg);
        xf = decode_mode(mode_reg);

        b_n   = s_restart ? '0 : batch_reg;
        b_c   = s_restart ? '0 : channel_reg;
        b_o   = s_restart ? '0 : outer_reg;
        b_i   = s_restart ? '0 : inner_reg;
        b_pos = s_restart ? '0 : position_reg;

        outer_lim = xf.rot ? wd : hd;
        inner_lim = xf.rot ? hd : wd;
        hc = xf.rot ? b_i : b_o;
        wc = xf.rot ? b_o : b_i;
        if (xf.flip_h) begin
            hc = DIM_BITS'(hd - DIM_W'(1) - DIM_W'(hc));
        end
        if (xf.flip_w) begin
            wc = DIM_BITS'(wd - DIM_W'(1) - DIM_W'(wc));
        end

        last = (DIM_W'(b_n) == nd - DIM_W'(1)) && (DIM_W'(b_c) == cd - DIM_W'(1)) &&
               (DIM_W'(b_o) == outer_lim - DIM_W'(1)) &&
               (DIM_W'(b_i) == inner_lim - DIM_W'(1));

        inner_inc   = DIM_W'(b_i) + DIM_W'(1);
        outer_inc   = DIM_W'(b_o) + DIM_W'(1);
        channel_inc = DIM_W'(b_c) + DIM_W'(1);
        batch_inc   = DIM_W'(b_n) + DIM_W'(1);

        inner_next   = DIM_BITS'(inner_inc);
        outer_next   = b_o;
        channel_next = b_c;
        batch_next   = b_n;
        if (inner_inc >= inner_lim) begin
            inner_next = '0;
            outer_next = DIM_BITS'(outer_inc);
            if (outer_inc >= outer_lim) begin
                outer_next   = '0;
                channel_next = DIM_BITS'(channel_inc);
                if (channel_inc >= cd) begin
                    channel_next = '0;
                    batch_next   = (batch_inc >= nd) ? '0 : DIM_BITS'(batch_inc);
                end
            end
        end
        position_next = last ? '0 : b_pos + IDX_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_hit) begin
            batch_reg    <= '0;
            channel_reg  <= '0;
            outer_reg    <= '0;
            inner_reg    <= '0;
            position_reg <= '0;
        end else if (accept) begin
            batch_reg    <= batch_next;
            channel_reg  <= channel_next;
            outer_reg    <= outer_next;
            inner_reg    <= inner_next;
            position_reg <= position_next;
        end
    end

    assign q_push      = accept;
    assign q_data.n    = b_n;
    assign q_data.c    = b_c;
    assign q_data.h    = hc;
    assign q_data.w    = wc;
    assign q_data.dest = b_pos;
    assign q_data.last = last;
    assign dims.hd     = hd;
    assign dims.wd     = wd;
    assign dims.cd     = cd;

endmodule

`default_nettype wire

// ===== sv/tlrag_fifo.sv =====
// Short coordinate request queue between the front and back ends.
// Register based, first word fall through. Depends on tlrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrag_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tlrag_pkg::coord_t din,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output tlrag_pkg::coord_t dout
);
    import tlrag_pkg::*;

    coord_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW:0]   wr_ptr_reg, rd_ptr_reg;

    assign not_empty = wr_ptr_reg != rd_ptr_reg;
    assign full      = (wr_ptr_reg[FIFO_AW] != rd_ptr_reg[FIFO_AW]) &&
                       (wr_ptr_reg[FIFO_AW-1:0] == rd_ptr_reg[FIFO_AW-1:0]);
    assign dout      = mem_reg[rd_ptr_reg[FIFO_AW-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (FIFO_AW+1)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (FIFO_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[FIFO_AW-1:0]] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tlrag_back.sv =====
// Back end: three-stage multiply-accumulate pipeline forming ((n*H+h)*W+w)*C+c,
// with the output register. Depends on tlrag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlrag_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  tlrag_pkg::coord_t           q_data,
    output logic                        q_pop,
    input  tlrag_pkg::dims_t            dims,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [tlrag_pkg::IDX_W-1:0] m_source_index,
    output logic [tlrag_pkg::IDX_W-1:0] m_dest_index,
    output logic                        m_last
);
    import tlrag_pkg::*;

    logic                v1_reg, v2_reg, v3_reg;
    logic [P1_W-1:0]     p1_reg, p1_next;
    logic [P2_W-1:0]     p2_reg, p2_next;
    logic [P3_W-1:0]     p3_next;
    logic [DIM_BITS-1:0] w1_reg, c1_reg, c2_reg;
    logic [IDX_W-1:0]    dest1_reg, dest2_reg, dest3_reg;
    logic                last1_reg, last2_reg, last3_reg;
    logic [IDX_W-1:0]    src_reg;
    logic                advance;

    assign advance = !v3_reg || m_ready;
    assign q_pop   = q_valid && advance;

    assign p1_next = P1_W'(P1_W'(q_data.n) * P1_W'(dims.hd)) + P1_W'(q_data.h);
    assign p2_next = P2_W'(P2_W'(p1_reg) * P2_W'(dims.wd)) + P2_W'(w1_reg);
    assign p3_next = P3_W'(P3_W'(p2_reg) * P3_W'(dims.cd)) + P3_W'(c2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_reg    <= p1_next;
            w1_reg    <= q_data.w;
            c1_reg    <= q_data.c;
            dest1_reg <= q_data.dest;
            last1_reg <= q_data.last;

            p2_reg    <= p2_next;
            c2_reg    <= c1_reg;
            dest2_reg <= dest1_reg;
            last2_reg <= last1_reg;

            src_reg   <= IDX_W'(p3_next);
            dest3_reg <= dest2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign m_valid        = v3_reg;
    assign m_source_index = src_reg;
    assign m_dest_index   = dest3_reg;
    assign m_last         = last3_reg;

endmodule

`default_nettype wire

// ===== sv/tensor_layout_rotate_address_gen.sv =====
// Sustains one step request per clock while the output is not stalled. Each accepted step
// passes through the queue, then the first two multiply stages of the index datapath; the
// third stage is the output register. The four-entry queue lets steps keep being accepted
// while the output is stalled; with the output stalled, at most seven requests are in
// flight before s_ready drops. Configuration writes take effect at once, clear the walk
// counters and are always accepted; there is no clearing pass after reset.
//
// Top level: front end, request queue and back end. Depends on tlrag_pkg, tlrag_front,
// tlrag_fifo and tlrag_back.
`timescale 1ns / 1ps
`default_nettype none

module tensor_layout_rotate_address_gen (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tlrag_pkg::IDX_W-1:0]      m_source_index,
    output logic [tlrag_pkg::IDX_W-1:0]      m_dest_index,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlrag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlrag_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlrag_pkg::*;

    coord_t push_data, pop_data;
    dims_t  dims;
    logic   q_push, q_full, q_pop, q_valid;

    tlrag_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_restart (s_restart),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data),
        .dims      (dims)
    );

    tlrag_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (pop_data)
    );

    tlrag_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .dims           (dims),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_source_index (m_source_index),
        .m_dest_index   (m_dest_index),
        .m_last         (m_last)
    );

endmodule

`default_nettype wire

// ===== sv/tlrag_checker.sv =====
// Port-level checker for the address generator, bound to the top level.
// Depends on tlrag_pkg and tensor_layout_rotate_address_gen.
`timescale 1ns / 1ps
`default_nettype none

module tlrag_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [tlrag_pkg::IDX_W-1:0] m_source_index,
    input logic [tlrag_pkg::IDX_W-1:0] m_dest_index,
    input logic                        m_last
);
    import tlrag_pkg::*;

    logic [CHK_CNT_W-1:0] pend_reg;
    logic                 in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // requests accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + CHK_CNT_W'(in_acc) - CHK_CNT_W'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_source_index) && $stable(m_dest_index) &&
                                $stable(m_last))
        else $error("result payload changed while stalled");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result without a pending request");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= CHK_CNT_W'(OUT_CAP))
        else $error("more requests in flight than the design can hold");

endmodule

bind tensor_layout_rotate_address_gen tlrag_checker u_tlrag_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_source_index (m_source_index),
    .m_dest_index   (m_dest_index),
    .m_last         (m_last)
);

`default_nettype wire
